[rtl/core/owbm_pkg.sv]
// ----------------------------------------------------------------------------
// owbm_pkg
// shared types and constants of the one-wire bus master
// ----------------------------------------------------------------------------
package owbm_pkg;

    localparam int unsigned TICK_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned BIT_W   = 3;
    localparam int unsigned IDX_W   = 3;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
    localparam logic [BIT_W-1:0]  LAST_BIT = {BIT_W{1'b1}};

    localparam logic [TICK_W-1:0] RST_RESET_LOW     = 16'd480;
    localparam logic [TICK_W-1:0] RST_PRESENCE_WAIT = 16'd80;
    localparam logic [TICK_W-1:0] RST_RESET_TAIL    = 16'd400;
    localparam logic [TICK_W-1:0] RST_SLOT          = 16'd60;
    localparam logic [TICK_W-1:0] RST_WRITE_ONE_LOW = 16'd1;
    localparam logic [TICK_W-1:0] RST_READ_LOW      = 16'd2;

    localparam logic [IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [IDX_W-1:0] REG_SLOT          = 3'd3;
    localparam logic [IDX_W-1:0] REG_WRITE_ONE_LOW = 3'd4;
    localparam logic [IDX_W-1:0] REG_READ_LOW      = 3'd5;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_RESET = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_RST_LOW  = 3'd1,
        PH_RST_WAIT = 3'd2,
        PH_RST_TAIL = 3'd3,
        PH_W_LOW    = 3'd4,
        PH_W_REST   = 3'd5,
        PH_R_LOW    = 3'd6,
        PH_R_REST   = 3'd7
    } t_phase;

    typedef struct packed {
        logic [TICK_W-1:0] reset_low_ticks;
        logic [TICK_W-1:0] presence_wait_ticks;
        logic [TICK_W-1:0] reset_tail_ticks;
        logic [TICK_W-1:0] slot_ticks;
        logic [TICK_W-1:0] write_one_low_ticks;
        logic [TICK_W-1:0] read_low_ticks;
    } t_cfg;

    typedef struct packed {
        t_phase            phase;
        t_kind             op_code;
        logic [TICK_W-1:0] tick_count;
        logic [BIT_W-1:0]  bit_index;
        logic [BYTE_W-1:0] shift_byte;
        logic              presence_flag;
        logic [BYTE_W-1:0] last_read;
        logic              sample_pending;
    } t_state;

    typedef struct packed {
        logic              drive_low;
        logic              busy_res;
        logic              done_res;
        logic              present;
        logic [BYTE_W-1:0] read_byte;
    } t_result;

endpackage

[rtl/core/owbm_if.sv]
// ----------------------------------------------------------------------------
// owbm interfaces
// input, result and register write channels of the one-wire bus master
// ----------------------------------------------------------------------------
interface owbm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] write_byte;
    logic       tick;
    logic       line_level;

    modport source (output valid, kind, write_byte, tick, line_level, input ready);
    modport sink   (input valid, kind, write_byte, tick, line_level, output ready);
endinterface

interface owbm_out_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       present;
    logic [7:0] read_byte;

    modport source (output valid, drive_low, busy_res, done_res, present, read_byte,
                    input ready);
    modport sink   (input valid, drive_low, busy_res, done_res, present, read_byte,
                    output ready);
endinterface

interface owbm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/one_wire_bus_master.sv]
// ----------------------------------------------------------------------------
// one_wire_bus_master
// results: one result beat per input beat, registered and valid in the cycle after acceptance
// throughput: one input beat per clock while results are taken; the result register frees when taken
// bus state advances once per accepted beat; the output register is the only
// buffer between the two sides, so input stalls only while a result waits
// reset: synchronous active low; timing registers return to 480/80/400/60/1/2
// and the master returns to idle with presence and read byte cleared
// ----------------------------------------------------------------------------
module one_wire_bus_master
    import owbm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    owbm_cfg_if.sink      i_cfg,
    owbm_in_if.sink       i_in,
    owbm_out_if.source    o_out
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_out_valid;
    logic    in_beat;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = ~r_out_valid | o_out.ready;
    assign in_beat     = i_in.valid & i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_ticks     <= RST_RESET_LOW;
            r_cfg.presence_wait_ticks <= RST_PRESENCE_WAIT;
            r_cfg.reset_tail_ticks    <= RST_RESET_TAIL;
            r_cfg.slot_ticks          <= RST_SLOT;
            r_cfg.write_one_low_ticks <= RST_WRITE_ONE_LOW;
            r_cfg.read_low_ticks      <= RST_READ_LOW;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_RESET_LOW:     r_cfg.reset_low_ticks     <= i_cfg.data;
                REG_PRESENCE_WAIT: r_cfg.presence_wait_ticks <= i_cfg.data;
                REG_RESET_TAIL:    r_cfg.reset_tail_ticks    <= i_cfg.data;
                REG_SLOT:          r_cfg.slot_ticks          <= i_cfg.data;
                REG_WRITE_ONE_LOW: r_cfg.write_one_low_ticks <= i_cfg.data;
                REG_READ_LOW:      r_cfg.read_low_ticks      <= i_cfg.data;
                default: ;
            endcase
        end
    end

    owbm_step u_step (
        .i_state      (r_state),
        .i_cfg        (r_cfg),
        .i_kind       (t_kind'(i_in.kind)),
        .i_write_byte (i_in.write_byte),
        .i_tick       (i_in.tick),
        .i_line_level (i_in.line_level),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= PH_IDLE;
            r_state.op_code        <= KIND_NONE;
            r_state.tick_count     <= '0;
            r_state.bit_index      <= '0;
            r_state.shift_byte     <= '0;
            r_state.presence_flag  <= 1'b0;
            r_state.last_read      <= '0;
            r_state.sample_pending <= 1'b0;
            r_out_valid            <= 1'b0;
        end else begin
            if (in_beat) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.drive_low = r_result.drive_low;
    assign o_out.busy_res  = r_result.busy_res;
    assign o_out.done_res  = r_result.done_res;
    assign o_out.present   = r_result.present;
    assign o_out.read_byte = r_result.read_byte;

endmodule

[rtl/core/owbm_step.sv]
// ----------------------------------------------------------------------------
// owbm_step
// next state and result of the bus master for one input beat
// ----------------------------------------------------------------------------
module owbm_step
    import owbm_pkg::*;
(
    input  t_state            i_state,
    input  t_cfg              i_cfg,
    input  t_kind             i_kind,
    input  logic [BYTE_W-1:0] i_write_byte,
    input  logic              i_tick,
    input  logic              i_line_level,
    output t_state            o_state,
    output t_result           o_result
);

    logic [TICK_W-1:0] len;
    logic              done;
    t_state            s;

    always_comb begin
        s    = i_state;
        done = 1'b0;
        len  = i_cfg.slot_ticks;
        if (i_state.phase == PH_IDLE) begin
            if (i_kind != KIND_NONE) begin
                s.op_code        = i_kind;
                s.tick_count     = '0;
                s.bit_index      = '0;
                s.sample_pending = 1'b0;
                case (i_kind)
                    KIND_RESET: begin
                        s.phase = PH_RST_LOW;
                    end
                    KIND_WRITE: begin
                        s.shift_byte = i_write_byte;
                        s.phase      = PH_W_LOW;
                    end
                    default: begin
                        s.shift_byte = '0;
                        s.phase      = PH_R_LOW;
                    end
                endcase
            end
        end else begin
            if (s.sample_pending && s.phase == PH_R_REST) begin
                s.shift_byte     = {i_line_level, s.shift_byte[BYTE_W-1:1]};
                s.sample_pending = 1'b0;
            end
            if (i_tick && s.tick_count != TICK_MAX) begin
                s.tick_count = s.tick_count + TICK_W'(1);
            end
            case (s.phase)
                PH_RST_LOW:  len = i_cfg.reset_low_ticks;
                PH_RST_WAIT: len = i_cfg.presence_wait_ticks;
                PH_RST_TAIL: len = i_cfg.reset_tail_ticks;
                PH_W_LOW:    len = s.shift_byte[0] ? i_cfg.write_one_low_ticks
                                                   : i_cfg.slot_ticks;
                PH_R_LOW:    len = i_cfg.read_low_ticks;
                default:     len = i_cfg.slot_ticks;
            endcase
            if (s.tick_count >= len) begin
                s.tick_count = '0;
                case (s.phase)
                    PH_RST_LOW: begin
                        s.phase = PH_RST_WAIT;
                    end
                    PH_RST_WAIT: begin
                        s.presence_flag = ~i_line_level;
                        s.phase         = PH_RST_TAIL;
                    end
                    PH_RST_TAIL: begin
                        s.phase = PH_IDLE;
                        done    = 1'b1;
                    end
                    PH_W_LOW: begin
                        if (s.shift_byte[0]) begin
                            s.phase = PH_W_REST;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    PH_W_REST: begin
                        done = 1'b1;
                    end
                    PH_R_LOW: begin
                        s.phase          = PH_R_REST;
                        s.sample_pending = 1'b1;
                    end
                    default: begin
                        if (s.sample_pending) begin
                            s.shift_byte     = {i_line_level, s.shift_byte[BYTE_W-1:1]};
                            s.sample_pending = 1'b0;
                        end
                        done = 1'b1;
                    end
                endcase
                // end of a bit slot
                if (done && s.phase != PH_RST_TAIL && s.phase != PH_IDLE) begin
                    if (s.op_code == KIND_WRITE) begin
                        s.shift_byte = {1'b0, s.shift_byte[BYTE_W-1:1]};
                    end
                    if (s.bit_index == LAST_BIT) begin
                        if (s.op_code == KIND_READ) begin
                            s.last_read = s.shift_byte;
                        end
                        s.phase = PH_IDLE;
                    end else begin
                        done        = 1'b0;
                        s.bit_index = s.bit_index + BIT_W'(1);
                        s.phase     = (s.op_code == KIND_WRITE) ? PH_W_LOW : PH_R_LOW;
                    end
                end
            end
        end
    end

    assign o_state            = s;
    assign o_result.drive_low = (s.phase == PH_RST_LOW) || (s.phase == PH_W_LOW)
                                || (s.phase == PH_R_LOW);
    assign o_result.busy_res  = (s.phase != PH_IDLE);
    assign o_result.done_res  = done;
    assign o_result.present   = s.presence_flag;
    assign o_result.read_byte = s.last_read;

endmodule
